@@ hdl/bmp_rle_pixel_decoder_assert.svh @@
// ============================================================================
// bmp_rle_pixel_decoder_assert.svh
// Assertion macros shared by the decoder modules. The enclosing module must
// provide clk and rst_n.
// ============================================================================
`ifndef BMP_RLE_PIXEL_DECODER_ASSERT_SVH
`define BMP_RLE_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BMPD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmpd: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define BMPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmpd: next-cycle check failed");

`endif

@@ hdl/bmpd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bmpd_pkg
// Types and constants shared by the bitmap RLE pixel decoder modules.
// ============================================================================
package bmpd_pkg;

    // Palette store geometry
    localparam int unsigned PALETTE_DEPTH = 256;
    localparam int unsigned PAL_AW        = $clog2(PALETTE_DEPTH);

    // Image limits
    localparam int unsigned MAX_DIMENSION = 8192;
    localparam logic [14:0] CURSOR_MAX    = 15'h7FFF;

    // Opaque black and alpha for palette colors
    localparam logic [31:0] OPAQUE        = 32'hFF00_0000;

    // Input operations
    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_STREAM  = 1'b1;

    // Escape codes after a zero first byte
    localparam logic [7:0] ESC_EOL   = 8'h00;
    localparam logic [7:0] ESC_EOB   = 8'h01;
    localparam logic [7:0] ESC_DELTA = 8'h02;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SPAN = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    // Parser phases
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_DX      = 3'd2,
        PH_DY      = 3'd3,
        PH_LITERAL = 3'd4,
        PH_PAD     = 3'd5
    } phase_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RLE4_MODE     = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_IMAGE_HEIGHT  = 3'd2,
        REG_TOP_DOWN      = 3'd3,
        REG_PALETTE_COUNT = 3'd4
    } reg_idx_t;

    // Work handed from the parser to the result stage
    typedef struct packed {
        logic        span_v;
        logic        status_v;
        kind_t       status_kind;
        logic [12:0] row;
        logic [12:0] column;
        logic [7:0]  count;
        logic [7:0]  idx_even;
        logic [7:0]  idx_odd;
    } item_t;

endpackage

@@ hdl/bmpd_palette_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bmpd_palette_ram
// Palette store: one write port, two read ports, registered read data.
// ============================================================================
module bmpd_palette_ram
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [bmpd_pkg::PAL_AW-1:0] waddr,
    input  logic [23:0]                wdata,
    input  logic                       re,
    input  logic [bmpd_pkg::PAL_AW-1:0] raddr_a,
    input  logic [bmpd_pkg::PAL_AW-1:0] raddr_b,
    output logic [23:0]                rdata_a,
    output logic [23:0]                rdata_b
);

    logic [23:0] mem [bmpd_pkg::PALETTE_DEPTH];
    logic [23:0] rdata_a_reg;
    logic [23:0] rdata_b_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read two entries, hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ hdl/bmpd_parser.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bmpd_parser
// Stream parser: walks the RLE byte pairs, keeps the cursor and builds the
// span and status work for each accepted word.
// ============================================================================
`include "bmp_rle_pixel_decoder_assert.svh"

module bmpd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                operation,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic                rle4_mode,
    input  logic [13:0]         image_width,
    input  logic [13:0]         image_height,
    input  logic                top_down,
    output bmpd_pkg::item_t     item,
    output logic                item_v
);

    bmpd_pkg::phase_t phase_reg, phase_next, phase_step;
    logic [7:0]  held_reg, held_next;
    logic [14:0] cur_x_reg, cur_x_next;
    logic [14:0] cur_y_reg, cur_y_next;
    logic [7:0]  lit_left_reg, lit_left_next;
    logic        pad_reg, pad_next;
    logic        fin_reg, fin_next;

    logic        stream_acc;
    logic [7:0]  lit_p;
    logic [7:0]  lit_rem;
    logic [7:0]  span_cnt;
    logic [15:0] x_sum;
    logic [14:0] x_adv;
    logic [7:0]  y_step;
    logic [15:0] y_sum;
    logic [14:0] y_adv;
    logic        in_view;
    logic [13:0] room;
    logic [7:0]  clip;
    logic [13:0] row_flip;
    logic [8:0]  lit_bytes;
    logic        pad_calc;
    logic        span_take;
    logic        eob_hit;
    logic        end_status;
    logic        bad_end;

    assign stream_acc = accept && (operation == bmpd_pkg::OP_STREAM);

    // Span length: encoded count or literal pixels of this byte
    assign lit_p    = (rle4_mode && (lit_left_reg >= 8'd2)) ? 8'd2 : 8'd1;
    assign lit_rem  = lit_left_reg - lit_p;
    assign span_cnt = (phase_reg == bmpd_pkg::PH_LITERAL) ? lit_p : held_reg;

    // Saturating cursor advance
    assign x_sum  = {1'b0, cur_x_reg} + {8'd0, span_cnt};
    assign x_adv  = x_sum[15] ? bmpd_pkg::CURSOR_MAX : x_sum[14:0];
    assign y_step = (phase_reg == bmpd_pkg::PH_DY) ? data_byte : 8'd1;
    assign y_sum  = {1'b0, cur_y_reg} + {8'd0, y_step};
    assign y_adv  = y_sum[15] ? bmpd_pkg::CURSOR_MAX : y_sum[14:0];

    // Clip to the image
    assign in_view  = (cur_y_reg < {1'b0, image_height}) &&
                      (cur_x_reg < {1'b0, image_width});
    assign room     = image_width - cur_x_reg[13:0];
    assign clip     = ({6'd0, span_cnt} < room) ? span_cnt : room[7:0];
    assign row_flip = image_height - 14'd1 - cur_y_reg[13:0];

    // Absolute run padding: odd byte count takes a pad byte
    assign lit_bytes = rle4_mode ? (({1'b0, data_byte} + 9'd1) >> 1) : {1'b0, data_byte};
    assign pad_calc  = lit_bytes[0];

    // Next state
    always_comb
    begin
        phase_step    = phase_reg;
        phase_next    = phase_reg;
        held_next     = held_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        lit_left_next = lit_left_reg;
        pad_next      = pad_reg;
        fin_next      = fin_reg;
        if (stream_acc)
        begin
            if (!fin_reg)
            begin
                case (phase_reg)
                    bmpd_pkg::PH_FIRST:
                    begin
                        held_next  = data_byte;
                        phase_step = bmpd_pkg::PH_SECOND;
                    end
                    bmpd_pkg::PH_SECOND:
                    begin
                        phase_step = bmpd_pkg::PH_FIRST;
                        if (held_reg != 8'd0)
                        begin
                            cur_x_next = x_adv;
                        end
                        else if (data_byte == bmpd_pkg::ESC_EOL)
                        begin
                            cur_x_next = '0;
                            cur_y_next = y_adv;
                        end
                        else if (data_byte == bmpd_pkg::ESC_EOB)
                        begin
                            fin_next = 1'b1;
                        end
                        else if (data_byte == bmpd_pkg::ESC_DELTA)
                        begin
                            phase_step = bmpd_pkg::PH_DX;
                        end
                        else
                        begin
                            lit_left_next = data_byte;
                            pad_next      = pad_calc;
                            phase_step    = bmpd_pkg::PH_LITERAL;
                        end
                    end
                    bmpd_pkg::PH_DX:
                    begin
                        held_next  = data_byte;
                        phase_step = bmpd_pkg::PH_DY;
                    end
                    bmpd_pkg::PH_DY:
                    begin
                        cur_x_next = x_adv;
                        cur_y_next = y_adv;
                        phase_step = bmpd_pkg::PH_FIRST;
                    end
                    bmpd_pkg::PH_LITERAL:
                    begin
                        cur_x_next    = x_adv;
                        lit_left_next = lit_rem;
                        if (lit_rem == 8'd0)
                        begin
                            phase_step = pad_reg ? bmpd_pkg::PH_PAD : bmpd_pkg::PH_FIRST;
                            pad_next   = 1'b0;
                        end
                    end
                    default:
                    begin
                        phase_step = bmpd_pkg::PH_FIRST;
                    end
                endcase
                phase_next = phase_step;
            end
            // Stream end: drop back to the reset state
            if (last_byte)
            begin
                phase_next    = bmpd_pkg::PH_FIRST;
                held_next     = '0;
                cur_x_next    = '0;
                cur_y_next    = '0;
                lit_left_next = '0;
                pad_next      = 1'b0;
                fin_next      = 1'b0;
            end
        end
    end

    // Outputs: span and status work for this word
    always_comb
    begin
        span_take  = stream_acc && !fin_reg &&
                     (((phase_reg == bmpd_pkg::PH_SECOND) && (held_reg != 8'd0)) ||
                      (phase_reg == bmpd_pkg::PH_LITERAL));
        eob_hit    = stream_acc && !fin_reg && (phase_reg == bmpd_pkg::PH_SECOND) &&
                     (held_reg == 8'd0) && (data_byte == bmpd_pkg::ESC_EOB);
        end_status = stream_acc && !fin_reg && last_byte && !eob_hit;
        bad_end    = (phase_step == bmpd_pkg::PH_DX) || (phase_step == bmpd_pkg::PH_DY) ||
                     (phase_step == bmpd_pkg::PH_LITERAL);

        item             = '0;
        item.span_v      = span_take && in_view;
        item.status_v    = eob_hit || end_status;
        item.status_kind = (end_status && bad_end) ? bmpd_pkg::KIND_BAD
                                                   : bmpd_pkg::KIND_DONE;
        item.row         = top_down ? cur_y_reg[12:0] : row_flip[12:0];
        item.column      = cur_x_reg[12:0];
        item.count       = clip;
        item.idx_even    = rle4_mode ? {4'd0, data_byte[7:4]} : data_byte;
        item.idx_odd     = rle4_mode ? {4'd0, data_byte[3:0]} : data_byte;
        item_v           = item.span_v || item.status_v;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= bmpd_pkg::PH_FIRST;
            held_reg     <= '0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            lit_left_reg <= '0;
            pad_reg      <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            held_reg     <= held_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            lit_left_reg <= lit_left_next;
            pad_reg      <= pad_next;
            fin_reg      <= fin_next;
        end
    end

    `BMPD_ASSERT_IMPLY(a_literal_nonempty, phase_reg == bmpd_pkg::PH_LITERAL, lit_left_reg != 8'd0)
    `BMPD_ASSERT_IMPLY(a_finished_at_first, fin_reg, phase_reg == bmpd_pkg::PH_FIRST)

endmodule

@@ hdl/bmpd_result_stage.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bmpd_result_stage
// Holds one parsed word while its palette reads land, forms the ARGB colors
// and feeds up to two results through the output register.
// ============================================================================
`include "bmp_rle_pixel_decoder_assert.svh"

module bmpd_result_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  bmpd_pkg::item_t item,
    input  logic [23:0]     rdata_even,
    input  logic [23:0]     rdata_odd,
    input  logic [8:0]      palette_count,
    input  logic            out_ready,
    output logic            free,
    output logic            out_valid,
    output logic [1:0]      kind,
    output logic [12:0]     row,
    output logic [12:0]     column,
    output logic [7:0]      pixel_count,
    output logic [31:0]     color_even,
    output logic [31:0]     color_odd,
    output logic            last_of_item
);

    logic            s1_valid_reg, s1_valid_next;
    bmpd_pkg::item_t s1_item_reg, s1_item_next;

    logic            out_valid_reg, out_valid_next;
    bmpd_pkg::kind_t out_kind_reg, out_kind_next;
    logic [12:0]     out_row_reg, out_row_next;
    logic [12:0]     out_col_reg, out_col_next;
    logic [7:0]      out_count_reg, out_count_next;
    logic [31:0]     out_ce_reg, out_ce_next;
    logic [31:0]     out_co_reg, out_co_next;
    logic            out_last_reg, out_last_next;

    logic            out_load;
    logic            s1_done;
    logic [31:0]     ce;
    logic [31:0]     co;

    // Palette lookup: entries past the count read as opaque black
    assign ce = ({1'b0, s1_item_reg.idx_even} < palette_count)
                ? (bmpd_pkg::OPAQUE | {8'd0, rdata_even}) : bmpd_pkg::OPAQUE;
    assign co = ({1'b0, s1_item_reg.idx_odd} < palette_count)
                ? (bmpd_pkg::OPAQUE | {8'd0, rdata_odd}) : bmpd_pkg::OPAQUE;

    // Advance when the output register is empty or being taken
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_done  = out_load && !(s1_item_reg.span_v && s1_item_reg.status_v);
    assign free     = !s1_valid_reg || s1_done;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_count_next = out_count_reg;
        out_ce_next    = out_ce_reg;
        out_co_next    = out_co_reg;
        out_last_next  = out_last_reg;
        s1_item_next   = s1_item_reg;
        s1_valid_next  = s1_valid_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (s1_item_reg.span_v)
            begin
                out_kind_next       = bmpd_pkg::KIND_SPAN;
                out_row_next        = s1_item_reg.row;
                out_col_next        = s1_item_reg.column;
                out_count_next      = s1_item_reg.count;
                out_ce_next         = ce;
                out_co_next         = co;
                out_last_next       = !s1_item_reg.status_v;
                s1_item_next.span_v = 1'b0;
            end
            else
            begin
                out_kind_next  = s1_item_reg.status_kind;
                out_row_next   = '0;
                out_col_next   = '0;
                out_count_next = '0;
                out_ce_next    = '0;
                out_co_next    = '0;
                out_last_next  = 1'b1;
            end
        end

        // Take a new word or retire the finished one
        if (load)
        begin
            s1_item_next  = item;
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_item_reg   <= s1_item_next;
        out_kind_reg  <= out_kind_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_count_reg <= out_count_next;
        out_ce_reg    <= out_ce_next;
        out_co_reg    <= out_co_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign row          = out_row_reg;
    assign column       = out_col_reg;
    assign pixel_count  = out_count_reg;
    assign color_even   = out_ce_reg;
    assign color_odd    = out_co_reg;
    assign last_of_item = out_last_reg;

    `BMPD_ASSERT_IMPLY(a_load_when_free, load, free)
    `BMPD_ASSERT_NEXT(a_split_keeps_status, out_load && s1_item_reg.span_v && s1_item_reg.status_v, s1_valid_reg && s1_item_reg.status_v && !s1_item_reg.span_v)
    `BMPD_ASSERT_IMPLY(a_span_not_empty, out_valid_reg && (out_kind_reg == bmpd_pkg::KIND_SPAN), out_count_reg != 8'd0)

endmodule

@@ hdl/bmp_rle_pixel_decoder.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bmp_rle_pixel_decoder
// Bitmap RLE8 / RLE4 decoder: one stream byte or palette write per word in,
// pixel spans and image status out.
// ============================================================================
// The decoder accepts one input word per clock while in_ready is high: a
// palette write or one byte of the RLE stream. The palette sits in a
// 256 x 24 memory with two read ports; both colors of a byte are read at
// the edge that accepts it and registered with the word in the result stage.
// A byte gives at most two results (a span followed by the end-of-stream
// status); such a byte holds the result stage until both have left, every
// other byte sustains one word per cycle while out_ready is high. Palette
// entries that were never written read as undefined colors. Configuration
// registers sit at byte addresses 0, 4, 8, 12 and 16; the user must write
// them only while the decoder is idle, which the block does not enforce.
// ============================================================================
module bmp_rle_pixel_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    // Input word
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  palette_index,
    input  logic [23:0] palette_color,
    input  logic        last_byte,
    // Result word
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [12:0] row,
    output logic [12:0] column,
    output logic [7:0]  pixel_count,
    output logic [31:0] color_even,
    output logic [31:0] color_odd,
    output logic        last_of_item,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        rle4_reg, rle4_next;
    logic [13:0] width_reg, width_next;
    logic [13:0] height_reg, height_next;
    logic        top_down_reg, top_down_next;
    logic [8:0]  pal_count_reg, pal_count_next;

    logic               cfg_wr;
    bmpd_pkg::reg_idx_t cfg_idx;
    logic [13:0]        wdata_dim;
    logic [8:0]         wdata_cnt;

    logic            accept;
    logic            item_v;
    bmpd_pkg::item_t item;
    logic            load;
    logic            free;
    logic            pal_we;
    logic [23:0]     rdata_even;
    logic [23:0]     rdata_odd;

    // Configuration writes with saturation
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = bmpd_pkg::reg_idx_t'(paddr[4:2]);
    assign wdata_dim = (pwdata[13:0] > 14'(bmpd_pkg::MAX_DIMENSION))
                       ? 14'(bmpd_pkg::MAX_DIMENSION) : pwdata[13:0];
    assign wdata_cnt = (pwdata[8:0] > 9'(bmpd_pkg::PALETTE_DEPTH))
                       ? 9'(bmpd_pkg::PALETTE_DEPTH) : pwdata[8:0];

    always_comb
    begin
        rle4_next      = rle4_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        top_down_next  = top_down_reg;
        pal_count_next = pal_count_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                bmpd_pkg::REG_RLE4_MODE:     rle4_next      = pwdata[0];
                bmpd_pkg::REG_IMAGE_WIDTH:   width_next     = wdata_dim;
                bmpd_pkg::REG_IMAGE_HEIGHT:  height_next    = wdata_dim;
                bmpd_pkg::REG_TOP_DOWN:      top_down_next  = pwdata[0];
                bmpd_pkg::REG_PALETTE_COUNT: pal_count_next = wdata_cnt;
                default:                     rle4_next      = rle4_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle4_reg      <= 1'b0;
            width_reg     <= 14'd1;
            height_reg    <= 14'd1;
            top_down_reg  <= 1'b0;
            pal_count_reg <= '0;
        end
        else
        begin
            rle4_reg      <= rle4_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            top_down_reg  <= top_down_next;
            pal_count_reg <= pal_count_next;
        end
    end

    // Register readback
    always_comb
    begin
        case (cfg_idx)
            bmpd_pkg::REG_RLE4_MODE:     prdata = {31'd0, rle4_reg};
            bmpd_pkg::REG_IMAGE_WIDTH:   prdata = {18'd0, width_reg};
            bmpd_pkg::REG_IMAGE_HEIGHT:  prdata = {18'd0, height_reg};
            bmpd_pkg::REG_TOP_DOWN:      prdata = {31'd0, top_down_reg};
            bmpd_pkg::REG_PALETTE_COUNT: prdata = {23'd0, pal_count_reg};
            default:                     prdata = '0;
        endcase
    end

    // Input handshake
    assign in_ready = free;
    assign accept   = in_valid && in_ready;
    assign load     = accept && item_v;
    assign pal_we   = accept && (operation == bmpd_pkg::OP_PALETTE) &&
                      ({1'b0, palette_index} < 9'(bmpd_pkg::PALETTE_DEPTH));

    bmpd_parser u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .operation    (operation),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .rle4_mode    (rle4_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .top_down     (top_down_reg),
        .item         (item),
        .item_v       (item_v)
    );

    bmpd_palette_ram u_palette
    (
        .clk     (clk),
        .we      (pal_we),
        .waddr   (palette_index[bmpd_pkg::PAL_AW-1:0]),
        .wdata   (palette_color),
        .re      (load),
        .raddr_a (item.idx_even[bmpd_pkg::PAL_AW-1:0]),
        .raddr_b (item.idx_odd[bmpd_pkg::PAL_AW-1:0]),
        .rdata_a (rdata_even),
        .rdata_b (rdata_odd)
    );

    bmpd_result_stage u_result
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .item          (item),
        .rdata_even    (rdata_even),
        .rdata_odd     (rdata_odd),
        .palette_count (pal_count_reg),
        .out_ready     (out_ready),
        .free          (free),
        .out_valid     (out_valid),
        .kind          (kind),
        .row           (row),
        .column        (column),
        .pixel_count   (pixel_count),
        .color_even    (color_even),
        .color_odd     (color_odd),
        .last_of_item  (last_of_item)
    );

endmodule
